@@ sv/dtt_pkg.sv @@
package dtt_pkg;

	// Widths of the cycle count and of the nanoseconds-per-second factor.
	localparam int CYC_W  = 32;
	localparam int NSEC_W = 30;

	localparam logic [NSEC_W-1:0] NS_PER_SEC = NSEC_W'(1000000000);

	// Command codes as they arrive on the operation port.
	typedef enum logic [1:0] {
		OP_SET     = 2'd0,
		OP_STOP    = 2'd1,
		OP_SERVICE = 2'd2,
		OP_BAD     = 2'd3
	} op_e;

	// Result codes as they leave on the kind port.
	typedef enum logic [1:0] {
		KIND_OK    = 2'd0,
		KIND_FAIL  = 2'd1,
		KIND_FIRED = 2'd2,
		KIND_DONE  = 2'd3
	} kind_e;

	// Command fields that travel from the front end to the slot engine.
	typedef struct packed {
		op_e         op;
		logic [15:0] handle;
		logic [7:0]  queue_id;
		logic [31:0] message;
		logic [63:0] now;
	} cmd_t;

endpackage

@@ sv/deadline_timer_table_core.sv @@
// A set converts its interval and, when its countdown is nonzero, its countdown before it
// reaches the slot engine; stop and service go straight there, and a bad opcode skips the scan.
// Fired results come one a cycle during the scan; the receiver cannot stall them.
// The front end can accept a new transaction while the slot engine works on earlier ones; busy
// is high from acceptance until the push, which waits while the two-entry queue to the slot engine is full.
// After reset all slots are free and the block is idle.
module deadline_timer_table_core #(
	parameter int          SLOTS      = 8,
	parameter int unsigned COUNTER_HZ = 46875000
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  operation,
	input  logic [15:0] handle,
	input  logic [31:0] countdown,
	input  logic [31:0] interval,
	input  logic [7:0]  queue_id,
	input  logic [31:0] message,
	input  logic [63:0] now,
	output logic        strobe,
	output logic [1:0]  kind,
	output logic [15:0] fired_handle,
	output logic [7:0]  fired_queue,
	output logic [31:0] fired_message,
	output logic        last
);

	// Widest nanosecond value that a 32-bit cycle count converts to.
	localparam logic [63:0] MAX_NS = (64'hFFFF_FFFF * 64'd1000000000) / 64'(COUNTER_HZ);
	localparam int NS_W  = $clog2(MAX_NS + 64'd1);
	localparam int ENT_W = $bits(dtt_pkg::cmd_t) + 2 * NS_W;

	logic               f_push;
	logic               q_full;
	logic               q_empty;
	logic               b_pop;
	dtt_pkg::cmd_t      f_cmd;
	logic [NS_W-1:0]    f_first;
	logic [NS_W-1:0]    f_period;
	logic [ENT_W-1:0]   q_din;
	logic [ENT_W-1:0]   q_dout;
	dtt_pkg::cmd_t      b_cmd;
	logic [NS_W-1:0]    b_first;
	logic [NS_W-1:0]    b_period;

	// Front end: accepts transactions and converts cycle counts to nanoseconds.
	dtt_front #(
		.COUNTER_HZ (COUNTER_HZ),
		.NS_W       (NS_W)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.operation (operation),
		.handle    (handle),
		.countdown (countdown),
		.interval  (interval),
		.queue_id  (queue_id),
		.message   (message),
		.now       (now),
		.push      (f_push),
		.full      (q_full),
		.cmd       (f_cmd),
		.first_ns  (f_first),
		.period_ns (f_period)
	);

	assign q_din = {f_cmd, f_first, f_period};

	// Queue between the two halves.
	dtt_queue #(
		.W (ENT_W)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (f_push),
		.din    (q_din),
		.full   (q_full),
		.pop    (b_pop),
		.dout   (q_dout),
		.empty  (q_empty)
	);

	assign {b_cmd, b_first, b_period} = q_dout;

	// Slot engine: scans the table and produces results.
	dtt_back #(
		.SLOTS (SLOTS),
		.NS_W  (NS_W)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.empty         (q_empty),
		.pop           (b_pop),
		.cmd           (b_cmd),
		.first_ns      (b_first),
		.period_ns     (b_period),
		.strobe        (strobe),
		.kind          (kind),
		.fired_handle  (fired_handle),
		.fired_queue   (fired_queue),
		.fired_message (fired_message),
		.last          (last)
	);

	// The front end is busy in the cycle after it accepts a transaction.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("front end not busy after accepting a transaction");

	// Fired results never close a transaction; done results always do.
	a_fired_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && kind == dtt_pkg::KIND_FIRED |-> !last)
		else $error("fired result marked last");

	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && kind == dtt_pkg::KIND_DONE |-> last)
		else $error("done result not marked last");

	// Timer fields are zero on every result that is not a fire.
	a_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && kind != dtt_pkg::KIND_FIRED |->
		fired_handle == 16'd0 && fired_queue == 8'd0 && fired_message == 32'd0)
		else $error("timer fields set on a non-fire result");

endmodule

@@ sv/dtt_queue.sv @@
module dtt_queue #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] din,
	output logic         full,
	input  logic         pop,
	output logic [W-1:0] dout,
	output logic         empty
);

	// Two-entry circular buffer between the front end and the slot engine.
	logic [W-1:0] mem_q [2];
	logic         wp_q;
	logic         rp_q;
	logic [1:0]   cnt_q;

	assign full  = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign dout  = mem_q[rp_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			if (push && !pop) cnt_q <= cnt_q + 2'd1;
			else if (pop && !push) cnt_q <= cnt_q - 2'd1;
		end
	end

	// Entry storage needs no reset.
	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= din;
	end

endmodule

@@ sv/dtt_front.sv @@
module dtt_front #(
	parameter int unsigned COUNTER_HZ = 46875000,
	parameter int          NS_W       = 37
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         operation,
	input  logic [15:0]        handle,
	input  logic [31:0]        countdown,
	input  logic [31:0]        interval,
	input  logic [7:0]         queue_id,
	input  logic [31:0]        message,
	input  logic [63:0]        now,
	output logic               push,
	input  logic               full,
	output dtt_pkg::cmd_t      cmd,
	output logic [NS_W-1:0]    first_ns,
	output logic [NS_W-1:0]    period_ns
);

	// Scaled reciprocal of the counter frequency. A 32-bit cycle count times it, shifted
	// right by SHIFT, gives the exact floor of cycles * 1e9 / COUNTER_HZ.
	localparam int SHIFT = dtt_pkg::CYC_W + $clog2(COUNTER_HZ);
	localparam logic [127:0] RECIP_W = ((128'(dtt_pkg::NS_PER_SEC) << SHIFT) +
		128'(COUNTER_HZ) - 128'd1) / 128'(COUNTER_HZ);
	localparam logic [63:0] RECIP = RECIP_W[63:0];

	typedef enum logic [2:0] {
		F_IDLE = 3'b001,
		F_MUL  = 3'b010,
		F_PUSH = 3'b100
	} fstate_t;

	fstate_t             state_q;
	logic                phase_q;
	logic                hi_q;
	logic [31:0]         cd_q;
	logic [31:0]         iv_q;
	logic [63:0]         lo_q;
	dtt_pkg::cmd_t       cmd_q;
	logic [NS_W-1:0]     first_q;
	logic [NS_W-1:0]     period_q;

	logic                accept;
	logic [31:0]         mul_a;
	logic [31:0]         mul_b;
	logic [63:0]         prod;
	logic [95:0]         sum;
	logic [NS_W-1:0]     ns;

	assign accept    = start && (state_q == F_IDLE);
	assign busy      = (state_q != F_IDLE);
	assign push      = (state_q == F_PUSH) && !full;
	assign cmd       = cmd_q;
	assign first_ns  = first_q;
	assign period_ns = period_q;

	// One 32 by 32 multiplier takes the low, then the high half of the reciprocal.
	assign mul_a = phase_q ? cd_q : iv_q;
	assign mul_b = hi_q ? RECIP[63:32] : RECIP[31:0];
	assign prod  = 64'(mul_a) * 64'(mul_b);
	assign sum   = {32'd0, lo_q} + {prod, 32'd0};
	assign ns    = NS_W'(sum >> SHIFT);

	// Accept a transaction, convert the interval of a set and, if nonzero, its countdown,
	// then hand it on.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= F_IDLE;
			phase_q  <= 1'b0;
			hi_q     <= 1'b0;
			cd_q     <= '0;
			iv_q     <= '0;
			lo_q     <= '0;
			cmd_q    <= '0;
			first_q  <= '0;
			period_q <= '0;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (accept) begin
						cmd_q.op       <= dtt_pkg::op_e'(operation);
						cmd_q.handle   <= handle;
						cmd_q.queue_id <= queue_id;
						cmd_q.message  <= message;
						cmd_q.now      <= now;
						cd_q           <= countdown;
						iv_q           <= interval;
						phase_q        <= 1'b0;
						hi_q           <= 1'b0;
						if (dtt_pkg::op_e'(operation) == dtt_pkg::OP_SET) state_q <= F_MUL;
						else state_q <= F_PUSH;
					end
				end
				F_MUL: begin
					if (!hi_q) begin
						lo_q <= prod;
						hi_q <= 1'b1;
					end else begin
						hi_q    <= 1'b0;
						first_q <= ns;
						if (!phase_q) begin
							period_q <= ns;
							if (cd_q != 32'd0) phase_q <= 1'b1;
							else state_q <= F_PUSH;
						end else begin
							state_q <= F_PUSH;
						end
					end
				end
				F_PUSH: begin
					if (!full) state_q <= F_IDLE;
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

endmodule

@@ sv/dtt_back.sv @@
module dtt_back #(
	parameter int SLOTS = 8,
	parameter int NS_W  = 37
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            empty,
	output logic            pop,
	input  dtt_pkg::cmd_t   cmd,
	input  logic [NS_W-1:0] first_ns,
	input  logic [NS_W-1:0] period_ns,
	output logic            strobe,
	output logic [1:0]      kind,
	output logic [15:0]     fired_handle,
	output logic [7:0]      fired_queue,
	output logic [31:0]     fired_message,
	output logic            last
);

	localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

	typedef struct packed {
		logic [15:0]     handle;
		logic [63:0]     deadline;
		logic [NS_W-1:0] period;
		logic [7:0]      queue_id;
		logic [31:0]     message;
	} slot_t;

	typedef enum logic [2:0] {
		B_IDLE   = 3'b001,
		B_SCAN   = 3'b010,
		B_FINISH = 3'b100
	} bstate_t;

	slot_t              mem_q [SLOTS];
	logic [SLOTS-1:0]   active_q;
	bstate_t            state_q;
	dtt_pkg::cmd_t      cur_q;
	logic [NS_W-1:0]    cur_first_q;
	logic [NS_W-1:0]    cur_period_q;
	logic [IDX_W-1:0]   a_q;
	logic               rd_go_q;
	logic               v_s1;
	logic [IDX_W-1:0]   idx_s1;
	slot_t              rdata_s1;
	logic               free_found_q;
	logic [IDX_W-1:0]   free_idx_q;

	logic               strobe_q;
	dtt_pkg::kind_e     kind_q;
	logic [15:0]        fhandle_q;
	logic [7:0]         fqueue_q;
	logic [31:0]        fmsg_q;
	logic               last_q;

	logic               act;
	logic               hmatch;
	logic               due;
	logic               stop_hit;
	logic               we;
	logic [IDX_W-1:0]   wa;
	slot_t              wd;
	dtt_pkg::kind_e     fin_kind;

	assign strobe        = strobe_q;
	assign kind          = kind_q;
	assign fired_handle  = fhandle_q;
	assign fired_queue   = fqueue_q;
	assign fired_message = fmsg_q;
	assign last          = last_q;

	assign pop = (state_q == B_IDLE) && !empty;

	// Tests on the slot whose entry was read in the previous cycle.
	assign act      = active_q[idx_s1];
	assign hmatch   = (rdata_s1.handle == cur_q.handle);
	assign due      = (cur_q.now >= rdata_s1.deadline);
	assign stop_hit = (state_q == B_SCAN) && v_s1 && (cur_q.op == dtt_pkg::OP_STOP) &&
		act && hmatch;

	// Final result of a transaction that scans to the end or has a bad opcode.
	always_comb begin
		case (cur_q.op)
			dtt_pkg::OP_SET:     fin_kind = free_found_q ? dtt_pkg::KIND_OK : dtt_pkg::KIND_FAIL;
			dtt_pkg::OP_SERVICE: fin_kind = dtt_pkg::KIND_DONE;
			default:             fin_kind = dtt_pkg::KIND_FAIL;
		endcase
	end

	// Slot memory write: shared-handle rewrite, periodic advance, or new timer.
	always_comb begin
		we = 1'b0;
		wa = idx_s1;
		wd = rdata_s1;
		if (state_q == B_SCAN && v_s1 && act) begin
			if (cur_q.op == dtt_pkg::OP_SET && hmatch) begin
				we          = 1'b1;
				wd.queue_id = cur_q.queue_id;
				wd.message  = cur_q.message;
			end else if (cur_q.op == dtt_pkg::OP_SERVICE && due &&
				rdata_s1.period != '0) begin
				we          = 1'b1;
				wd.deadline = rdata_s1.deadline + 64'(rdata_s1.period);
			end
		end else if (state_q == B_FINISH && cur_q.op == dtt_pkg::OP_SET && free_found_q) begin
			we          = 1'b1;
			wa          = free_idx_q;
			wd.handle   = cur_q.handle;
			wd.deadline = cur_q.now + 64'(cur_first_q);
			wd.period   = cur_period_q;
			wd.queue_id = cur_q.queue_id;
			wd.message  = cur_q.message;
		end
	end

	// Slot memory with one write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) mem_q[wa] <= wd;
		rdata_s1 <= mem_q[a_q];
	end

	// Scan sequencer, active bits and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= B_IDLE;
			active_q     <= '0;
			cur_q        <= '0;
			cur_first_q  <= '0;
			cur_period_q <= '0;
			a_q          <= '0;
			rd_go_q      <= 1'b0;
			v_s1         <= 1'b0;
			idx_s1       <= '0;
			free_found_q <= 1'b0;
			free_idx_q   <= '0;
			strobe_q     <= 1'b0;
			kind_q       <= dtt_pkg::KIND_OK;
			fhandle_q    <= '0;
			fqueue_q     <= '0;
			fmsg_q       <= '0;
			last_q       <= 1'b0;
		end else begin
			strobe_q  <= 1'b0;
			kind_q    <= dtt_pkg::KIND_OK;
			fhandle_q <= '0;
			fqueue_q  <= '0;
			fmsg_q    <= '0;
			last_q    <= 1'b0;
			idx_s1    <= a_q;
			v_s1      <= 1'b0;
			case (state_q)
				B_IDLE: begin
					if (!empty) begin
						cur_q        <= cmd;
						cur_first_q  <= first_ns;
						cur_period_q <= period_ns;
						a_q          <= '0;
						free_found_q <= 1'b0;
						free_idx_q   <= '0;
						if (cmd.op == dtt_pkg::OP_BAD) begin
							state_q <= B_FINISH;
						end else begin
							rd_go_q <= 1'b1;
							state_q <= B_SCAN;
						end
					end
				end
				B_SCAN: begin
					if (rd_go_q) begin
						v_s1 <= 1'b1;
						if (a_q == LAST_IDX) rd_go_q <= 1'b0;
						else a_q <= a_q + IDX_W'(1);
					end
					if (v_s1) begin
						case (cur_q.op)
							dtt_pkg::OP_SET: begin
								if (!act && !free_found_q) begin
									free_found_q <= 1'b1;
									free_idx_q   <= idx_s1;
								end
							end
							dtt_pkg::OP_SERVICE: begin
								if (act && due) begin
									strobe_q  <= 1'b1;
									kind_q    <= dtt_pkg::KIND_FIRED;
									fhandle_q <= rdata_s1.handle;
									fqueue_q  <= rdata_s1.queue_id;
									fmsg_q    <= rdata_s1.message;
									if (rdata_s1.period == '0) active_q[idx_s1] <= 1'b0;
								end
							end
							default: ;
						endcase
						if (stop_hit) begin
							active_q[idx_s1] <= 1'b0;
							strobe_q         <= 1'b1;
							kind_q           <= dtt_pkg::KIND_OK;
							last_q           <= 1'b1;
							rd_go_q          <= 1'b0;
							v_s1             <= 1'b0;
							state_q          <= B_IDLE;
						end else if (idx_s1 == LAST_IDX) begin
							state_q <= B_FINISH;
						end
					end
				end
				B_FINISH: begin
					strobe_q <= 1'b1;
					kind_q   <= fin_kind;
					last_q   <= 1'b1;
					if (cur_q.op == dtt_pkg::OP_SET && free_found_q)
						active_q[free_idx_q] <= 1'b1;
					state_q <= B_IDLE;
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

endmodule
